// File: rtl/core/ddgp_pkg.sv
// Shared constants, types and table functions for the go-to-point steering block.
// No dependencies; used by ddgp_front, ddgp_queue, ddgp_back and diff_drive_goto_point.
`default_nettype none
package ddgp_pkg;

    // Default sizes for the top-level parameters
    localparam int COORD_WIDTH_DEF   = 10;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed field widths
    localparam int INDEX_W   = 4;
    localparam int HEADING_W = 15;
    localparam int SPEED_W   = 8;
    localparam int CRUISE_W  = 7;
    localparam int GAIN_W    = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CRUISE_W-1:0]  CRUISE_RST = 7'd127;
    localparam logic [GAIN_W-1:0]    GAIN_RST   = 10'd200;

    // Arithmetic constants
    localparam int GUARD_BITS  = 8;
    localparam int TWO_PI_W    = 27;
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q24 = 27'd105414357;
    localparam int SPEED_LIMIT = 127;
    localparam int QUEUE_DEPTH = 4;

    // Heading conversion: a turn is 5760 sixteenths = 45 * 2^7
    localparam int HEAD_TURN  = 5760;
    localparam int HEAD_DIV   = 45;
    localparam int HEAD_SHIFT = 7;
    localparam int HEAD_RECIP = 23302;   // ceil(2^20 / 45), exact for h < 5760
    localparam int HEAD_RSH   = 20;

    typedef struct packed {
        logic [CRUISE_W-1:0] cruise;
        logic [GAIN_W-1:0]   gain;
    } t_cfg;

    // Width of one front-to-back queue entry
    function automatic int item_width(input int cw, input int aw);
        return INDEX_W + 2 * (cw + 1) + aw + 1;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic longint unsigned atan_turn32(input int i);
        case (i)
            0:       return 64'd536870912;
            1:       return 64'd316933406;
            2:       return 64'd167458907;
            3:       return 64'd85004756;
            4:       return 64'd42667331;
            5:       return 64'd21354465;
            6:       return 64'd10679838;
            7:       return 64'd5340245;
            8:       return 64'd2670163;
            9:       return 64'd1335087;
            10:      return 64'd667544;
            11:      return 64'd333772;
            12:      return 64'd166886;
            13:      return 64'd83443;
            14:      return 64'd41721;
            15:      return 64'd20860;
            16:      return 64'd10430;
            17:      return 64'd5215;
            18:      return 64'd2607;
            19:      return 64'd1303;
            20:      return 64'd651;
            21:      return 64'd325;
            22:      return 64'd162;
            default: return 64'd81;
        endcase
    endfunction

    // Stage angle rounded to aw-bit binary angle
    function automatic longint unsigned stage_angle(input int i, input int aw);
        return (atan_turn32(i) + (64'd1 << (31 - aw))) >> (32 - aw);
    endfunction

    // Fractional part of the heading conversion for remainder k of h / 45
    function automatic int unsigned head_frac(input int unsigned k, input int aw);
        return ((k << (aw - HEAD_SHIFT)) + 22) / HEAD_DIV;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ddgp_front.sv
// Front end: accepts a pose item, forms the offset, target flag and binary-angle heading.
// Depends on ddgp_pkg; feeds ddgp_queue.
`default_nettype none
module ddgp_front #(
    parameter int COORD_WIDTH = ddgp_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ddgp_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [ddgp_pkg::INDEX_W-1:0]        i_robot_index,
    input  wire logic [COORD_WIDTH-1:0]              i_robot_x,
    input  wire logic [COORD_WIDTH-1:0]              i_robot_y,
    input  wire logic signed [ddgp_pkg::HEADING_W-1:0] i_robot_heading,
    input  wire logic [COORD_WIDTH-1:0]              i_target_x,
    input  wire logic [COORD_WIDTH-1:0]              i_target_y,
    output logic                                     o_valid,
    output logic [ddgp_pkg::item_width(COORD_WIDTH, ANGLE_WIDTH)-1:0] o_item,
    input  wire logic                                i_full
);
    import ddgp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int UW = 17;
    localparam int HW = 13;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        logic [AW-1:0]      hba;
        logic               at;
    } t_item;

    // Stage 1 registers
    logic               r_v1;
    logic [INDEX_W-1:0] r_idx1;
    logic signed [CW:0] r_dx1;
    logic signed [CW:0] r_dy1;
    logic               r_at1;
    logic [HW-1:0]      r_hm1;
    // Stage 2 registers
    logic               r_v2;
    t_item              r_item2;

    logic          adv1;
    logic          adv2;
    logic [UW-1:0] hu;
    logic [HW-1:0] n_hm;
    logic [26:0]   prod;
    logic [6:0]    qh;
    logic [HW-1:0] qh45;
    logic [5:0]    rh;
    logic [AW-1:0] frac;
    t_item         n_item;

    assign adv2    = !r_v2 || !i_full;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v2;
    assign o_item  = r_item2;

    // Heading modulo one turn: offset to positive, then pick the multiple of a turn
    always_comb begin
        hu = {{(UW-HEADING_W){i_robot_heading[HEADING_W-1]}}, i_robot_heading}
             + UW'(3 * HEAD_TURN);
        if (hu >= UW'(5 * HEAD_TURN)) begin
            n_hm = HW'(hu - UW'(5 * HEAD_TURN));
        end else if (hu >= UW'(4 * HEAD_TURN)) begin
            n_hm = HW'(hu - UW'(4 * HEAD_TURN));
        end else if (hu >= UW'(3 * HEAD_TURN)) begin
            n_hm = HW'(hu - UW'(3 * HEAD_TURN));
        end else if (hu >= UW'(2 * HEAD_TURN)) begin
            n_hm = HW'(hu - UW'(2 * HEAD_TURN));
        end else if (hu >= UW'(HEAD_TURN)) begin
            n_hm = HW'(hu - UW'(HEAD_TURN));
        end else begin
            n_hm = HW'(hu);
        end
    end

    // Binary angle = (h/45) * 2^(AW-7) + rounded fraction of the remainder
    always_comb begin
        prod = 27'(r_hm1) * 27'(HEAD_RECIP);
        qh   = prod[HEAD_RSH+6:HEAD_RSH];
        qh45 = HW'(qh) * HW'(HEAD_DIV);
        rh   = 6'(r_hm1 - qh45);
        frac = '0;
        for (int k = 0; k < HEAD_DIV; k++) begin
            if (rh == 6'(k)) begin
                frac = AW'(head_frac(k, AW));
            end
        end
        n_item.idx = r_idx1;
        n_item.dx  = r_dx1;
        n_item.dy  = r_dy1;
        n_item.at  = r_at1;
        n_item.hba = {qh, {(AW-HEAD_SHIFT){1'b0}}} + frac;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_idx1 <= i_robot_index;
            r_dx1  <= $signed({1'b0, i_target_x}) - $signed({1'b0, i_robot_x});
            r_dy1  <= $signed({1'b0, i_target_y}) - $signed({1'b0, i_robot_y});
            r_at1  <= (i_target_x == i_robot_x) && (i_target_y == i_robot_y);
            r_hm1  <= n_hm;
        end
        if (adv2) begin
            r_item2 <= n_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ddgp_queue.sv
// Short register queue between the front and back ends.
// Depends on ddgp_pkg for its depth.
`default_nettype none
module ddgp_queue #(
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_pop
);
    import ddgp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PW + 1;

    logic [DATA_W-1:0] r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ddgp_back.sv
// Back end: pipelined vectoring CORDIC for the bearing, then heading error and wheel speeds.
// Depends on ddgp_pkg; takes entries from ddgp_queue.
`default_nettype none
module ddgp_back #(
    parameter int COORD_WIDTH   = ddgp_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ddgp_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = ddgp_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire ddgp_pkg::t_cfg                       i_cfg,
    input  wire logic                                 i_q_valid,
    input  wire logic [ddgp_pkg::item_width(COORD_WIDTH, ANGLE_WIDTH)-1:0] i_q_item,
    output logic                                      o_q_pop,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [ddgp_pkg::INDEX_W-1:0]              o_robot_index_out,
    output logic signed [ddgp_pkg::SPEED_W-1:0]       o_left_speed,
    output logic signed [ddgp_pkg::SPEED_W-1:0]       o_right_speed,
    output logic                                      o_at_target,
    output logic                                      o_reversing
);
    import ddgp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int NS = CORDIC_STAGES;
    localparam int XW = CW + 1 + GUARD_BITS + 2;
    localparam int EGW = AW + GAIN_W + 1;
    localparam int PW = EGW + TWO_PI_W + 1;
    localparam int SH = 24 + AW;
    localparam int QW = PW - SH + 2;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        logic [AW-1:0]      hba;
        logic               at;
    } t_item;

    localparam logic signed [AW-1:0] QUARTER  = {2'b01, {(AW-2){1'b0}}};
    localparam logic signed [AW-1:0] NQUARTER = {2'b11, {(AW-2){1'b0}}};
    localparam logic [AW-1:0]        HALF     = {1'b1, {(AW-1){1'b0}}};

    t_item item;
    logic  adv;

    // CORDIC pipeline registers; index 0 is the half-turn pre-rotation
    logic               r_vc  [0:NS];
    logic signed [XW-1:0] r_x [0:NS];
    logic signed [XW-1:0] r_y [0:NS];
    logic [AW-1:0]      r_z   [0:NS];
    logic [AW-1:0]      r_hba [0:NS];
    logic [INDEX_W-1:0] r_idx [0:NS];
    logic               r_at  [0:NS];
    logic signed [XW-1:0] n_x [1:NS];
    logic signed [XW-1:0] n_y [1:NS];
    logic [AW-1:0]      n_z   [1:NS];

    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;

    // Steering stages
    logic               r_v1, r_v2, r_v3;
    logic signed [AW-1:0] r_e1;
    logic signed [SPEED_W-1:0] r_sv1, r_sv2, r_sv3;
    logic               r_rev1, r_rev2, r_rev3;
    logic               r_at1, r_at2, r_at3;
    logic [INDEX_W-1:0] r_idx1, r_idx2, r_idx3;
    logic signed [EGW-1:0] r_eg2;
    logic signed [PW-1:0]  r_p3;

    // Output register
    logic               r_out_v;
    logic [INDEX_W-1:0] r_out_idx;
    logic signed [SPEED_W-1:0] r_out_l;
    logic signed [SPEED_W-1:0] r_out_r;
    logic               r_out_at;
    logic               r_out_rev;

    logic [AW-1:0]        eu;
    logic                 fold;
    logic signed [AW-1:0] n_e;
    logic signed [SPEED_W-1:0] n_sv;
    logic signed [QW-2-1:0] pq;
    logic                 nz;
    logic signed [QW-1:0] fl, fr, ql, qr;

    function automatic logic signed [SPEED_W-1:0] sat(input logic signed [QW-1:0] q);
        if (q > QW'(SPEED_LIMIT)) begin
            return SPEED_W'(SPEED_LIMIT);
        end else if (q < -QW'(SPEED_LIMIT)) begin
            return -SPEED_W'(SPEED_LIMIT);
        end
        return SPEED_W'(q);
    endfunction

    assign item    = t_item'(i_q_item);
    assign adv     = !r_out_v || !i_stall;
    assign o_q_pop = adv;

    assign o_valid           = r_out_v;
    assign o_robot_index_out = r_out_idx;
    assign o_left_speed      = r_out_l;
    assign o_right_speed     = r_out_r;
    assign o_at_target       = r_out_at;
    assign o_reversing       = r_out_rev;

    // Scaled offset for the pre-rotation
    assign x0 = XW'(item.dx) <<< GUARD_BITS;
    assign y0 = XW'(item.dy) <<< GUARD_BITS;

    // CORDIC micro-rotations, one per stage
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            if (!r_y[s][XW-1]) begin
                n_x[s+1] = r_x[s] + (r_y[s] >>> s);
                n_y[s+1] = r_y[s] - (r_x[s] >>> s);
                n_z[s+1] = r_z[s] + AW'(stage_angle(s, AW));
            end else begin
                n_x[s+1] = r_x[s] - (r_y[s] >>> s);
                n_y[s+1] = r_y[s] + (r_x[s] >>> s);
                n_z[s+1] = r_z[s] - AW'(stage_angle(s, AW));
            end
        end
    end

    // Heading error, folded by a half turn when behind the robot
    always_comb begin
        eu   = r_z[NS] - r_hba[NS];
        fold = ($signed(eu) > QUARTER) || ($signed(eu) < NQUARTER);
        n_e  = fold ? $signed(eu ^ HALF) : $signed(eu);
        n_sv = fold ? -$signed({1'b0, i_cfg.cruise}) : $signed({1'b0, i_cfg.cruise});
    end

    // Truncate toward zero: floor part from the shifted product, fix-up on negatives
    always_comb begin
        pq = r_p3[PW-1:SH];
        nz = |r_p3[SH-1:0];
        fl = QW'(r_sv3) + QW'(pq);
        fr = QW'(r_sv3) - QW'(pq) - QW'(nz);
        ql = fl + QW'(fl[QW-1] && nz);
        qr = fr + QW'(fr[QW-1] && nz);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_vc[s] <= 1'b0;
            end
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_vc[0] <= i_q_valid;
            for (int s = 0; s < NS; s++) begin
                r_vc[s+1] <= r_vc[s];
            end
            r_v1    <= r_vc[NS];
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_out_v <= r_v3;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // pre-rotation
            if (item.dx[CW]) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= HALF;
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= '0;
            end
            r_hba[0] <= item.hba;
            r_idx[0] <= item.idx;
            r_at[0]  <= item.at;
            // CORDIC stages
            for (int s = 0; s < NS; s++) begin
                r_x[s+1]   <= n_x[s+1];
                r_y[s+1]   <= n_y[s+1];
                r_z[s+1]   <= n_z[s+1];
                r_hba[s+1] <= r_hba[s];
                r_idx[s+1] <= r_idx[s];
                r_at[s+1]  <= r_at[s];
            end
            // error and base speed
            r_e1   <= n_e;
            r_sv1  <= n_sv;
            r_rev1 <= fold;
            r_at1  <= r_at[NS];
            r_idx1 <= r_idx[NS];
            // error times gain
            r_eg2  <= r_e1 * $signed({1'b0, i_cfg.gain});
            r_sv2  <= r_sv1;
            r_rev2 <= r_rev1;
            r_at2  <= r_at1;
            r_idx2 <= r_idx1;
            // times 2*pi in Q24
            r_p3   <= r_eg2 * $signed({1'b0, TWO_PI_Q24});
            r_sv3  <= r_sv2;
            r_rev3 <= r_rev2;
            r_at3  <= r_at2;
            r_idx3 <= r_idx2;
            // saturated result; robot on target gives zero speeds
            r_out_idx <= r_idx3;
            r_out_at  <= r_at3;
            if (r_at3) begin
                r_out_l   <= '0;
                r_out_r   <= '0;
                r_out_rev <= 1'b0;
            end else begin
                r_out_l   <= sat(ql);
                r_out_r   <= sat(qr);
                r_out_rev <= r_rev3;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/diff_drive_goto_point.sv
// Go-to-point steering for a two-wheeled robot: top level with configuration registers.
// Depends on ddgp_pkg, ddgp_front, ddgp_queue and ddgp_back.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one item (robot index, pose, target).
//   An item is taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one result per item, in order:
//   robot index, left and right wheel speeds (-127..127), at-target and reversing flags.
//   Throughput: one item per cycle while the receiver does not stall. From accept to
//   o_out_valid an item passes the two front stages, the queue, the pre-rotation, one
//   CORDIC stage per micro-rotation, three steering stages (error, gain multiply,
//   2*pi multiply) and the output register.
//   When the receiver stalls, the back pipeline holds; the four-entry queue and the two
//   front stages keep taking items until they fill, then o_in_stall rises.
//   Configuration: i_cfg_we with i_cfg_index (0 cruise speed, 1 steer gain) and
//   i_cfg_data; write only while the block is idle. Other indexes are ignored.
//   Reset (synchronous, active low) empties the pipeline and queue and sets cruise
//   speed to 127 and steer gain to 200.
`default_nettype none
module diff_drive_goto_point #(
    parameter int COORD_WIDTH   = ddgp_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ddgp_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = ddgp_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [ddgp_pkg::INDEX_W-1:0]          i_robot_index,
    input  wire logic [COORD_WIDTH-1:0]                i_robot_x,
    input  wire logic [COORD_WIDTH-1:0]                i_robot_y,
    input  wire logic signed [ddgp_pkg::HEADING_W-1:0] i_robot_heading,
    input  wire logic [COORD_WIDTH-1:0]                i_target_x,
    input  wire logic [COORD_WIDTH-1:0]                i_target_y,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [ddgp_pkg::INDEX_W-1:0]               o_robot_index_out,
    output logic signed [ddgp_pkg::SPEED_W-1:0]        o_left_speed,
    output logic signed [ddgp_pkg::SPEED_W-1:0]        o_right_speed,
    output logic                                       o_at_target,
    output logic                                       o_reversing,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ddgp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ddgp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ddgp_pkg::*;

    localparam int ITEM_W = item_width(COORD_WIDTH, ANGLE_WIDTH);

    logic [CRUISE_W-1:0] r_cruise;
    logic [GAIN_W-1:0]   r_gain;
    t_cfg                cfg;

    logic              f_valid;
    logic [ITEM_W-1:0] f_item;
    logic              q_full;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item;
    logic              q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= CRUISE_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CRUISE: r_cruise <= i_cfg_data[CRUISE_W-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg.cruise = r_cruise;
    assign cfg.gain   = r_gain;

    // Front end: offset, target flag, heading angle
    ddgp_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_robot_index   (i_robot_index),
        .i_robot_x       (i_robot_x),
        .i_robot_y       (i_robot_y),
        .i_robot_heading (i_robot_heading),
        .i_target_x      (i_target_x),
        .i_target_y      (i_target_y),
        .o_valid         (f_valid),
        .o_item          (f_item),
        .i_full          (q_full)
    );

    // Decoupling queue
    ddgp_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_item),
        .i_pop   (q_pop)
    );

    // Back end: bearing and wheel speeds
    ddgp_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_robot_index_out (o_robot_index_out),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_at_target       (o_at_target),
        .o_reversing       (o_reversing)
    );

endmodule
`default_nettype wire
